>>> rtl/core/intel_hex_record_parser_unit_macros.svh
// Assertion macros shared by the parser RTL.
// No dependencies; pulled in by the modules that carry assertions.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IHEX_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IHEX_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ihex_pkg.sv
// Types, codes and helpers for the Intel HEX record parser.
// No dependencies; used by intel_hex_record_parser_unit.
package ihex_pkg;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_OK    = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_CSUM  = 3'd3,
    KIND_COLON = 3'd4,
    KIND_TYPE  = 3'd5,
    KIND_DIGIT = 3'd6
  } kind_e;

  // Record position: start/skip, then high/low nibble of each field byte.
  typedef enum logic [3:0] {
    PH_COLON = 4'd0,
    PH_SKIP  = 4'd1,
    PH_CNT_H = 4'd2,
    PH_CNT_L = 4'd3,
    PH_AHI_H = 4'd4,
    PH_AHI_L = 4'd5,
    PH_ALO_H = 4'd6,
    PH_ALO_L = 4'd7,
    PH_TYP_H = 4'd8,
    PH_TYP_L = 4'd9,
    PH_DAT_H = 4'd10,
    PH_DAT_L = 4'd11,
    PH_CHK_H = 4'd12,
    PH_CHK_L = 4'd13
  } phase_e;

  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  REC_DATA   = 8'h00;
  localparam logic [7:0]  REC_EOF    = 8'h01;
  localparam logic [7:0]  REC_EXT    = 8'h04;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 96;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.bad = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.val = c[3:0] + 4'd9;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/intel_hex_record_parser_unit.sv
// Intel HEX record parser, top level.
// Channels: slave side takes one ASCII character per item in s_axis_tdata_i,
//   with s_axis_tlast_i marking end of stream (character then ignored).
// Master side gives at most one result per character: tuser holds the kind
//   (data byte, record ok, done with size, or one of four errors), tdata holds
//   address, data byte, image size and line number.
// Path: a character is held in the input register; its result is then
//   registered in the output register, which drives m_axis_tvalid_o.
// Throughput: one character per clock while the output register is empty or
//   m_axis_tready_i is high, set by the single decode step between the input
//   and output registers (32-bit address add plus compare).
// Stall: when m_axis_tready_i is low the result holds; one more character
//   waits in the input register, then s_axis_tready_o drops.
// Reset (async, rst_ni low) clears parse state, base address, highest address
//   and line count, and empties both registers.
// After end of stream, a type 01 record or any error the block swallows all
//   further characters without results until reset.
`include "intel_hex_record_parser_unit_macros.svh"

module intel_hex_record_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [ihex_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic        s_axis_tlast_i,                        // stream_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] byte_address, [39:32] data_byte, [72:40] image_size,
  // [88:73] line_number, [95:89] zero
  output logic [ihex_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [2:0]  m_axis_tuser_o                         // [2:0] result_kind
);

  // input register
  logic       in_v_q;
  logic [7:0] in_char_q;
  logic       in_end_q;
  logic       adv;

  // parse state
  ihex_pkg::phase_e phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  rkind_q, rkind_d;
  logic [15:0] offset_q, offset_d;
  logic [31:0] upper_q, upper_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] highest_q, highest_d;
  logic [15:0] line_q, line_d;
  logic        halted_q, halted_d;

  // result of the current character
  logic              res_v;
  ihex_pkg::kind_e   res_kind;
  logic [31:0]       res_addr;
  logic [7:0]        res_data;
  logic [32:0]       res_size;
  logic [15:0]       res_line;

  // output register
  logic              out_v_q;
  ihex_pkg::kind_e   out_kind_q;
  logic [31:0]       out_addr_q;
  logic [7:0]        out_data_q;
  logic [32:0]       out_size_q;
  logic [15:0]       out_line_q;

  ihex_pkg::hex_digit_t hd;
  logic [7:0]  byte_v;
  logic [7:0]  sum_new;
  logic [7:0]  idx_inc;
  logic [31:0] data_addr;

  assign adv             = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i[7:0];
      in_end_q  <= s_axis_tlast_i;
    end
  end

  assign hd        = ihex_pkg::hex_decode(in_char_q);
  assign byte_v    = {nib_q, hd.val};
  assign sum_new   = sum_q + byte_v;
  assign idx_inc   = idx_q + 8'd1;
  assign data_addr = (upper_q | {16'd0, offset_q}) + {24'd0, idx_q};

  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    idx_d     = idx_q;
    len_d     = len_q;
    rkind_d   = rkind_q;
    offset_d  = offset_q;
    upper_d   = upper_q;
    sum_d     = sum_q;
    highest_d = highest_q;
    line_d    = line_q;
    halted_d  = halted_q;
    res_v     = 1'b0;
    res_kind  = ihex_pkg::KIND_DATA;
    res_addr  = 32'd0;
    res_data  = 8'd0;
    res_size  = 33'd0;
    res_line  = line_q;

    if (!halted_q) begin
      if (in_end_q) begin
        halted_d = 1'b1;
        res_v    = 1'b1;
        res_kind = ihex_pkg::KIND_DONE;
        res_size = {1'b0, highest_q} + 33'd1;
      end else if (phase_q == ihex_pkg::PH_COLON) begin
        if (in_char_q != ihex_pkg::CHAR_COLON) begin
          halted_d = 1'b1;
          res_v    = 1'b1;
          res_kind = ihex_pkg::KIND_COLON;
          res_line = (line_q == ihex_pkg::LINE_MAX) ? line_q : line_q + 16'd1;
        end else begin
          if (line_q != ihex_pkg::LINE_MAX) line_d = line_q + 16'd1;
          sum_d   = 8'd0;
          idx_d   = 8'd0;
          phase_d = ihex_pkg::PH_CNT_H;
        end
      end else if (phase_q == ihex_pkg::PH_SKIP) begin
        if (in_char_q == ihex_pkg::CHAR_LF) phase_d = ihex_pkg::PH_COLON;
      end else if (hd.bad) begin
        halted_d = 1'b1;
        res_v    = 1'b1;
        res_kind = ihex_pkg::KIND_DIGIT;
      end else if (!phase_q[0]) begin
        // high nibble of any field byte
        nib_d   = hd.val;
        phase_d = ihex_pkg::phase_e'(phase_q + 4'd1);
      end else begin
        sum_d = sum_new;
        unique case (phase_q)
          ihex_pkg::PH_CNT_L: begin
            len_d   = byte_v;
            phase_d = ihex_pkg::PH_AHI_H;
          end
          ihex_pkg::PH_AHI_L: begin
            offset_d = {byte_v, 8'd0};
            phase_d  = ihex_pkg::PH_ALO_H;
          end
          ihex_pkg::PH_ALO_L: begin
            offset_d = {offset_q[15:8], offset_q[7:0] | byte_v};
            phase_d  = ihex_pkg::PH_TYP_H;
          end
          ihex_pkg::PH_TYP_L: begin
            rkind_d = byte_v;
            if (byte_v == ihex_pkg::REC_EOF) begin
              halted_d = 1'b1;
              res_v    = 1'b1;
              res_kind = ihex_pkg::KIND_DONE;
              res_size = {1'b0, highest_q} + 33'd1;
            end else if (byte_v != ihex_pkg::REC_DATA && byte_v != ihex_pkg::REC_EXT) begin
              halted_d = 1'b1;
              res_v    = 1'b1;
              res_kind = ihex_pkg::KIND_TYPE;
            end else begin
              if (byte_v == ihex_pkg::REC_EXT) upper_d = 32'd0;
              idx_d   = 8'd0;
              phase_d = (len_q != 8'd0) ? ihex_pkg::PH_DAT_H : ihex_pkg::PH_CHK_H;
            end
          end
          ihex_pkg::PH_DAT_L: begin
            if (rkind_q == ihex_pkg::REC_DATA) begin
              if (highest_q < data_addr) highest_d = data_addr;
              res_v    = 1'b1;
              res_kind = ihex_pkg::KIND_DATA;
              res_addr = data_addr;
              res_data = byte_v;
            end else begin
              upper_d = {upper_q[23:0], byte_v};
            end
            idx_d   = idx_inc;
            phase_d = (idx_inc == len_q) ? ihex_pkg::PH_CHK_H : ihex_pkg::PH_DAT_H;
          end
          ihex_pkg::PH_CHK_L: begin
            if (sum_new != 8'd0) begin
              halted_d = 1'b1;
              res_v    = 1'b1;
              res_kind = ihex_pkg::KIND_CSUM;
            end else begin
              if (rkind_q == ihex_pkg::REC_EXT) upper_d = {upper_q[15:0], 16'd0};
              phase_d  = ihex_pkg::PH_SKIP;
              res_v    = 1'b1;
              res_kind = ihex_pkg::KIND_OK;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ihex_pkg::PH_COLON;
    end else if (adv) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_q     <= 4'd0;
      idx_q     <= 8'd0;
      len_q     <= 8'd0;
      rkind_q   <= 8'd0;
      offset_q  <= 16'd0;
      upper_q   <= 32'd0;
      sum_q     <= 8'd0;
      highest_q <= 32'd0;
      line_q    <= 16'd0;
      halted_q  <= 1'b0;
    end else if (adv) begin
      nib_q     <= nib_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      rkind_q   <= rkind_d;
      offset_q  <= offset_d;
      upper_q   <= upper_d;
      sum_q     <= sum_d;
      highest_q <= highest_d;
      line_q    <= line_d;
      halted_q  <= halted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= res_v;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q <= res_kind;
      out_addr_q <= res_addr;
      out_data_q <= res_data;
      out_size_q <= res_size;
      out_line_q <= res_line;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {7'd0, out_line_q, out_size_q, out_data_q, out_addr_q};

  // once stopped, the parser never resumes without reset
  `IHEX_ASSERT_NXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q, "parser left halted state")
  // errors and end of image stop the parser
  `IHEX_ASSERT_NXT(a_stop_on_final, clk_i, rst_ni,
    adv && res_v && res_kind != ihex_pkg::KIND_DATA && res_kind != ihex_pkg::KIND_OK,
    halted_q, "final result without halt")
  // a stopped parser produces no new result
  `IHEX_ASSERT_NXT(a_quiet_halted, clk_i, rst_ni, halted_q && adv, !out_v_q, "result while halted")
  // highest address covers every byte shown
  `IHEX_ASSERT_IMP(a_highest_cover, clk_i, rst_ni,
    out_v_q && out_kind_q == ihex_pkg::KIND_DATA,
    highest_q >= out_addr_q, "highest address below emitted byte")

endmodule
